// ----- rtl/core/pire_pkg.sv -----
// Shared widths, constants and types for the rotated-ellipse point test.
// No dependencies; every other file but pire_isqrt refers to it by scoped names.
`default_nettype none

package pire_pkg;

    localparam int unsigned COORD_W    = 32;  // Q16.16 coordinates and radius
    localparam int unsigned DIFF_W     = 33;  // point minus centre
    localparam int unsigned ANGLE_W    = 16;  // Q3.13 rotation
    localparam int unsigned ASPECT_W   = 16;  // Q8.8 shape
    localparam int unsigned KROOT_W    = 24;  // sqrt(s*s-1) in Q.16
    localparam int unsigned FOCAL_W    = 40;  // focal offset c, Q24.16
    localparam int unsigned BOUND_W    = 49;  // 2*r*s, Q.24
    localparam int unsigned TRIG_W     = 32;  // series terms and sums, Q.24
    localparam int unsigned SQR_W      = 29;  // angle squared, Q.24
    localparam int unsigned ANG24_W    = 27;  // |angle| in Q.24
    localparam int unsigned UNIT_W     = 26;  // |cos|, |sin| in Q.24
    localparam int unsigned OFS_W      = 42;  // focal offset components
    localparam int unsigned MAG_W      = 43;  // distance component magnitudes
    localparam int unsigned DROOT_W    = 44;  // point-to-focus distance
    localparam int unsigned TERMS      = 13;  // series terms after the first
    localparam int unsigned FRAC_SHIFT = 24;

    localparam logic [ASPECT_W-1:0] ASPECT_ONE    = 16'h0100;
    localparam logic [31:0]         ASPECT_ONE_SQ = 32'h0001_0000;
    localparam logic [TRIG_W-1:0]   TRIG_ONE      = 32'h0100_0000;

    typedef struct packed {
        logic [UNIT_W-1:0] cos_mag;
        logic              cos_neg;
        logic [UNIT_W-1:0] sin_mag;
        logic              sin_neg;
    } t_trig_res;

endpackage

`default_nettype wire

// ----- rtl/core/pire_isqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Uses no package items; carries a sideband vector alongside each transaction.
`default_nettype none

module pire_isqrt #(
    parameter int unsigned ROOT_W = 24,
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_vld,
    input  wire logic [2*ROOT_W-1:0]   i_rad,
    input  wire logic [SIDE_W-1:0]     i_side,
    output logic                       o_vld,
    output logic [ROOT_W-1:0]          o_root,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int unsigned RAD_W = 2 * ROOT_W;
    localparam int unsigned REM_W = ROOT_W + 1;
    localparam int unsigned TRY_W = ROOT_W + 3;

    logic [ROOT_W-1:0] r_vld;
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    logic [REM_W-1:0]  n_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_root [ROOT_W];
    logic [RAD_W-1:0]  n_rad  [ROOT_W];

    always_comb begin
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [RAD_W-1:0]  p_rad;
        logic [TRY_W-1:0]  shifted;
        logic [TRY_W:0]    diff;
        for (int i = 0; i < ROOT_W; i++) begin
            if (i == 0) begin
                p_rem  = '0;
                p_root = '0;
                p_rad  = i_rad;
            end else begin
                p_rem  = r_rem[i-1];
                p_root = r_root[i-1];
                p_rad  = r_rad[i-1];
            end
            shifted = {p_rem, p_rad[RAD_W-1 -: 2]};
            diff    = {1'b0, shifted} - {2'b00, p_root, 2'b01};
            // keep the trial when it does not borrow
            if (!diff[TRY_W]) begin
                n_rem[i]  = diff[REM_W-1:0];
                n_root[i] = {p_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[i]  = shifted[REM_W-1:0];
                n_root[i] = {p_root[ROOT_W-2:0], 1'b0};
            end
            n_rad[i] = p_rad << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ROOT_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ROOT_W; i++) begin
            r_rem[i]  <= n_rem[i];
            r_root[i] <= n_root[i];
            r_rad[i]  <= n_rad[i];
            if (i == 0) begin
                r_side[i] <= i_side;
            end else begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

`default_nettype wire

// ----- rtl/core/pire_trig.sv -----
// Pipelined cosine and sine of |angle| by Taylor series, three stages a term.
// Depends on pire_pkg for widths, the series length and the result struct.
`default_nettype none

module pire_trig #(
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire logic [pire_pkg::ANG24_W-1:0]  i_angle,
    input  wire logic [SIDE_W-1:0]             i_side,
    output logic                               o_vld,
    output pire_pkg::t_trig_res                o_res,
    output logic [SIDE_W-1:0]                  o_side
);

    localparam int unsigned TW = pire_pkg::TRIG_W;
    localparam int unsigned NT = pire_pkg::TERMS;

    typedef struct packed {
        logic [TW-1:0]               tc;
        logic [TW-1:0]               ts;
        logic [TW-1:0]               cp;
        logic [TW-1:0]               cn;
        logic [TW-1:0]               sp;
        logic [TW-1:0]               sn;
        logic [pire_pkg::SQR_W-1:0]  a2;
    } t_acc;

    logic                           r_e_vld;
    logic [pire_pkg::ANG24_W-1:0]   r_e_a;
    logic [pire_pkg::SQR_W-1:0]     r_e_a2;
    logic [SIDE_W-1:0]              r_e_side;
    logic [2*pire_pkg::ANG24_W-1:0] w_a_sq;

    t_acc              w_acc  [NT+1];
    logic [NT:0]       w_vld;
    logic [SIDE_W-1:0] w_side [NT+1];

    assign w_a_sq = i_angle * i_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_a    <= i_angle;
        r_e_a2   <= w_a_sq[pire_pkg::FRAC_SHIFT +: pire_pkg::SQR_W];
        r_e_side <= i_side;
    end

    always_comb begin
        w_acc[0].tc = pire_pkg::TRIG_ONE;
        w_acc[0].ts = TW'(r_e_a);
        w_acc[0].cp = pire_pkg::TRIG_ONE;
        w_acc[0].cn = '0;
        w_acc[0].sp = TW'(r_e_a);
        w_acc[0].sn = '0;
        w_acc[0].a2 = r_e_a2;
    end
    assign w_vld[0]  = r_e_vld;
    assign w_side[0] = r_e_side;

    for (genvar t = 0; t < NT; t++) begin : g_term
        localparam logic [TW-1:0] DC  = TW'((2*t+1)*(2*t+2));
        localparam logic [TW-1:0] DS  = TW'((2*t+2)*(2*t+3));
        localparam logic [TW-1:0] MC  = TW'((64'd1 << TW) / DC);
        localparam logic [TW-1:0] MS  = TW'((64'd1 << TW) / DS);
        localparam bit            ODD = (t % 2) == 0;

        logic                         r_a_vld, r_b_vld, r_c_vld;
        t_acc                         r_a_acc, r_b_acc, r_c_acc;
        logic [TW-1:0]                r_a_xc, r_a_xs, r_b_xc, r_b_xs, r_b_qc, r_b_qs;
        logic [SIDE_W-1:0]            r_a_side, r_b_side, r_c_side;
        logic [TW+pire_pkg::SQR_W-1:0] w_pc, w_ps;
        logic [2*TW-1:0]              w_mc, w_ms;
        logic [TW-1:0]                w_rc, w_rs, w_tc, w_ts;
        t_acc                         n_acc;

        assign w_pc = w_acc[t].tc * w_acc[t].a2;
        assign w_ps = w_acc[t].ts * w_acc[t].a2;
        assign w_mc = r_a_xc * MC;
        assign w_ms = r_a_xs * MS;

        // quotient estimate is low by at most one: correct on the remainder
        always_comb begin
            w_rc  = r_b_xc - r_b_qc * DC;
            w_rs  = r_b_xs - r_b_qs * DS;
            w_tc  = (w_rc >= DC) ? r_b_qc + 1'b1 : r_b_qc;
            w_ts  = (w_rs >= DS) ? r_b_qs + 1'b1 : r_b_qs;
            n_acc = r_b_acc;
            n_acc.tc = w_tc;
            n_acc.ts = w_ts;
            if (ODD) begin
                n_acc.cn = r_b_acc.cn + w_tc;
                n_acc.sn = r_b_acc.sn + w_ts;
            end else begin
                n_acc.cp = r_b_acc.cp + w_tc;
                n_acc.sp = r_b_acc.sp + w_ts;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld <= 1'b0;
                r_b_vld <= 1'b0;
                r_c_vld <= 1'b0;
            end else begin
                r_a_vld <= w_vld[t];
                r_b_vld <= r_a_vld;
                r_c_vld <= r_b_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_a_acc  <= w_acc[t];
            r_a_xc   <= w_pc[pire_pkg::FRAC_SHIFT +: TW];
            r_a_xs   <= w_ps[pire_pkg::FRAC_SHIFT +: TW];
            r_a_side <= w_side[t];
            r_b_acc  <= r_a_acc;
            r_b_xc   <= r_a_xc;
            r_b_xs   <= r_a_xs;
            r_b_qc   <= w_mc[2*TW-1:TW];
            r_b_qs   <= w_ms[2*TW-1:TW];
            r_b_side <= r_a_side;
            r_c_acc  <= n_acc;
            r_c_side <= r_b_side;
        end

        assign w_acc[t+1]  = r_c_acc;
        assign w_vld[t+1]  = r_c_vld;
        assign w_side[t+1] = r_c_side;
    end

    logic                r_o_vld;
    pire_pkg::t_trig_res r_o_res;
    logic [SIDE_W-1:0]   r_o_side;
    pire_pkg::t_trig_res n_res;

    always_comb begin
        n_res.cos_neg = w_acc[NT].cp < w_acc[NT].cn;
        n_res.sin_neg = w_acc[NT].sp < w_acc[NT].sn;
        n_res.cos_mag = n_res.cos_neg
                      ? pire_pkg::UNIT_W'(w_acc[NT].cn - w_acc[NT].cp)
                      : pire_pkg::UNIT_W'(w_acc[NT].cp - w_acc[NT].cn);
        n_res.sin_mag = n_res.sin_neg
                      ? pire_pkg::UNIT_W'(w_acc[NT].sn - w_acc[NT].sp)
                      : pire_pkg::UNIT_W'(w_acc[NT].sp - w_acc[NT].sn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= w_vld[NT];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_res  <= n_res;
        r_o_side <= w_side[NT];
    end

    assign o_vld  = r_o_vld;
    assign o_res  = r_o_res;
    assign o_side = r_o_side;

endmodule

`default_nettype wire

// ----- rtl/core/pire_sqsum.sv -----
// Two-stage sum of squares of two magnitudes, split into half-width products.
// Depends on pire_pkg for the magnitude and root widths.
`default_nettype none

module pire_sqsum #(
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_vld,
    input  wire logic [pire_pkg::MAG_W-1:0]     i_mx,
    input  wire logic [pire_pkg::MAG_W-1:0]     i_my,
    input  wire logic [SIDE_W-1:0]              i_side,
    output logic                                o_vld,
    output logic [2*pire_pkg::DROOT_W-1:0]      o_sum,
    output logic [SIDE_W-1:0]                   o_side
);

    localparam int unsigned LO_W  = (pire_pkg::MAG_W + 1) / 2;
    localparam int unsigned HI_W  = pire_pkg::MAG_W - LO_W;
    localparam int unsigned SUM_W = 2 * pire_pkg::DROOT_W;

    logic                   r1_vld, r2_vld;
    logic [2*HI_W-1:0]      r_xhh, r_yhh;
    logic [HI_W+LO_W-1:0]   r_xhl, r_yhl;
    logic [2*LO_W-1:0]      r_xll, r_yll;
    logic [SIDE_W-1:0]      r1_side, r2_side;
    logic [SUM_W-1:0]       r2_sum;
    logic [SUM_W-1:0]       n_sum;

    always_comb begin
        n_sum = (SUM_W'(r_xhh) << (2*LO_W)) + (SUM_W'(r_xhl) << (LO_W+1))
              + SUM_W'(r_xll)
              + (SUM_W'(r_yhh) << (2*LO_W)) + (SUM_W'(r_yhl) << (LO_W+1))
              + SUM_W'(r_yll);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xhh   <= i_mx[pire_pkg::MAG_W-1:LO_W] * i_mx[pire_pkg::MAG_W-1:LO_W];
        r_xhl   <= i_mx[pire_pkg::MAG_W-1:LO_W] * i_mx[LO_W-1:0];
        r_xll   <= i_mx[LO_W-1:0] * i_mx[LO_W-1:0];
        r_yhh   <= i_my[pire_pkg::MAG_W-1:LO_W] * i_my[pire_pkg::MAG_W-1:LO_W];
        r_yhl   <= i_my[pire_pkg::MAG_W-1:LO_W] * i_my[LO_W-1:0];
        r_yll   <= i_my[LO_W-1:0] * i_my[LO_W-1:0];
        r1_side <= i_side;
        r2_sum  <= n_sum;
        r2_side <= r1_side;
    end

    assign o_vld  = r2_vld;
    assign o_sum  = r2_sum;
    assign o_side = r2_side;

endmodule

`default_nettype wire

// ----- rtl/core/point_in_rotated_ellipse.sv -----
// Top level of the rotated-ellipse point test: focal offset, trig, distances.
// Depends on pire_pkg, pire_isqrt, pire_trig and pire_sqsum.
//
// A fully pipelined test that takes one transaction on every clock cycle:
// busy is always low, so start alone accepts an item. The registered strobe
// o_done marks each result, to be taken at the edge that samples it high;
// the path runs through the two bit-serial square-root pipelines (24 and 44
// stages) and the trig series, 13 terms after the first at three stages per
// term. Results leave in the order items arrived, each on the outputs for
// exactly one cycle; the receiver cannot hold them off and must take every
// result as it appears. The block has no state to set up.
`default_nettype none

module point_in_rotated_ellipse (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [pire_pkg::COORD_W-1:0]  i_point_x,
    input  wire logic signed [pire_pkg::COORD_W-1:0]  i_point_y,
    input  wire logic signed [pire_pkg::COORD_W-1:0]  i_center_x,
    input  wire logic signed [pire_pkg::COORD_W-1:0]  i_center_y,
    input  wire logic        [pire_pkg::COORD_W-1:0]  i_minor_radius,
    input  wire logic signed [pire_pkg::ANGLE_W-1:0]  i_rotation,
    input  wire logic        [pire_pkg::ASPECT_W-1:0] i_aspect,
    output logic                                      o_done,
    output logic                                      o_inside_res
);

    localparam int unsigned CW  = pire_pkg::COORD_W;
    localparam int unsigned DW  = pire_pkg::DIFF_W;
    localparam int unsigned AW  = pire_pkg::ANGLE_W;
    localparam int unsigned SW  = pire_pkg::ASPECT_W;
    localparam int unsigned BW  = pire_pkg::BOUND_W;
    localparam int unsigned FW  = pire_pkg::FOCAL_W;
    localparam int unsigned KW  = pire_pkg::KROOT_W;
    localparam int unsigned UW  = pire_pkg::UNIT_W;
    localparam int unsigned OW  = pire_pkg::OFS_W;
    localparam int unsigned MW  = pire_pkg::MAG_W;
    localparam int unsigned RW  = pire_pkg::DROOT_W;
    localparam int unsigned XW  = MW + 1;
    localparam int unsigned CLO = 32;
    localparam int unsigned SIDEK_W = 2*DW + CW + BW + AW + 2;
    localparam int unsigned SIDET_W = 2*DW + FW + BW + 2;

    assign busy = 1'b0;

    // ---- capture ----
    logic                 r_a_vld;
    logic signed [CW-1:0] r_a_px, r_a_py, r_a_cx, r_a_cy;
    logic [CW-1:0]        r_a_r;
    logic signed [AW-1:0] r_a_rot;
    logic [SW-1:0]        r_a_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_px  <= i_point_x;
        r_a_py  <= i_point_y;
        r_a_cx  <= i_center_x;
        r_a_cy  <= i_center_y;
        r_a_r   <= i_minor_radius;
        r_a_rot <= i_rotation;
        r_a_s   <= i_aspect;
    end

    // ---- shape terms, bound, offsets from centre ----
    logic                 r_b_vld;
    logic signed [DW-1:0] r_b_ex, r_b_ey;
    logic [CW-1:0]        r_b_r, r_b_q;
    logic [BW-1:0]        r_b_bound;
    logic [AW-1:0]        r_b_amag;
    logic                 r_b_neg, r_b_below;
    logic [2*SW-1:0]      w_ss;
    logic [CW+SW-1:0]     w_rs;
    logic [AW-1:0]        w_rot_u;

    assign w_ss    = r_a_s * r_a_s;
    assign w_rs    = r_a_r * r_a_s;
    assign w_rot_u = $unsigned(r_a_rot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_ex    <= DW'(r_a_px) - DW'(r_a_cx);
        r_b_ey    <= DW'(r_a_py) - DW'(r_a_cy);
        r_b_r     <= r_a_r;
        r_b_q     <= w_ss - pire_pkg::ASPECT_ONE_SQ;
        r_b_bound <= {w_rs, 1'b0};
        r_b_neg   <= r_a_rot[AW-1];
        r_b_amag  <= r_a_rot[AW-1] ? (~w_rot_u + 1'b1) : w_rot_u;
        r_b_below <= r_a_s < pire_pkg::ASPECT_ONE;
    end

    // ---- sqrt(s*s-1) ----
    logic                 w_k_vld;
    logic [KW-1:0]        w_k;
    logic [SIDEK_W-1:0]   w_k_side;
    logic signed [DW-1:0] w_k_ex, w_k_ey;
    logic [CW-1:0]        w_k_r;
    logic [BW-1:0]        w_k_bound;
    logic [AW-1:0]        w_k_amag;
    logic                 w_k_neg, w_k_below;

    pire_isqrt #(
        .ROOT_W (KW),
        .SIDE_W (SIDEK_W)
    ) u_isqrt_k (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_b_vld),
        .i_rad   ({r_b_q, 16'h0000}),
        .i_side  ({r_b_ex, r_b_ey, r_b_r, r_b_bound, r_b_amag, r_b_neg, r_b_below}),
        .o_vld   (w_k_vld),
        .o_root  (w_k),
        .o_side  (w_k_side)
    );

    assign {w_k_ex, w_k_ey, w_k_r, w_k_bound, w_k_amag, w_k_neg, w_k_below} = w_k_side;

    // ---- focal offset c ----
    logic                 r_c_vld;
    logic [FW-1:0]        r_c_c;
    logic signed [DW-1:0] r_c_ex, r_c_ey;
    logic [BW-1:0]        r_c_bound;
    logic [AW-1:0]        r_c_amag;
    logic                 r_c_neg, r_c_below;
    logic [CW+KW-1:0]     w_rk;

    assign w_rk = w_k_r * w_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= w_k_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_c     <= w_rk[16 +: FW];
        r_c_ex    <= w_k_ex;
        r_c_ey    <= w_k_ey;
        r_c_bound <= w_k_bound;
        r_c_amag  <= w_k_amag;
        r_c_neg   <= w_k_neg;
        r_c_below <= w_k_below;
    end

    // ---- cos and sin ----
    logic                 w_t_vld;
    pire_pkg::t_trig_res  w_t_res;
    logic [SIDET_W-1:0]   w_t_side;
    logic signed [DW-1:0] w_t_ex, w_t_ey;
    logic [FW-1:0]        w_t_c;
    logic [BW-1:0]        w_t_bound;
    logic                 w_t_neg, w_t_below;

    pire_trig #(
        .SIDE_W (SIDET_W)
    ) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_c_vld),
        .i_angle ({r_c_amag, 11'b0}),
        .i_side  ({r_c_ex, r_c_ey, r_c_c, r_c_bound, r_c_neg, r_c_below}),
        .o_vld   (w_t_vld),
        .o_res   (w_t_res),
        .o_side  (w_t_side)
    );

    assign {w_t_ex, w_t_ey, w_t_c, w_t_bound, w_t_neg, w_t_below} = w_t_side;

    // ---- offset partial products ----
    logic                 r_o_vld;
    logic [CLO+UW-1:0]    r_o_pcl, r_o_psl;
    logic [FW-CLO+UW-1:0] r_o_pch, r_o_psh;
    logic                 r_o_cneg, r_o_sneg;
    logic signed [DW-1:0] r_o_ex, r_o_ey;
    logic [BW-1:0]        r_o_bound;
    logic                 r_o_below;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= w_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_pcl   <= w_t_c[CLO-1:0] * w_t_res.cos_mag;
        r_o_pch   <= w_t_c[FW-1:CLO] * w_t_res.cos_mag;
        r_o_psl   <= w_t_c[CLO-1:0] * w_t_res.sin_mag;
        r_o_psh   <= w_t_c[FW-1:CLO] * w_t_res.sin_mag;
        r_o_cneg  <= w_t_res.cos_neg;
        // sine follows the sign of the rotation
        r_o_sneg  <= w_t_res.sin_neg ^ w_t_neg;
        r_o_ex    <= w_t_ex;
        r_o_ey    <= w_t_ey;
        r_o_bound <= w_t_bound;
        r_o_below <= w_t_below;
    end

    // ---- signed focal offsets ----
    localparam int unsigned PW = FW + UW + 2;

    logic                 r_f_vld;
    logic signed [OW:0]   r_f_ox, r_f_oy;
    logic signed [DW-1:0] r_f_ex, r_f_ey;
    logic [BW-1:0]        r_f_bound;
    logic                 r_f_below;
    logic [PW-1:0]        w_oxp, w_oyp;
    logic [OW:0]          w_oxm, w_oym;

    assign w_oxp = (PW'(r_o_pch) << CLO) + PW'(r_o_pcl);
    assign w_oyp = (PW'(r_o_psh) << CLO) + PW'(r_o_psl);
    assign w_oxm = {1'b0, w_oxp[pire_pkg::FRAC_SHIFT +: OW]};
    assign w_oym = {1'b0, w_oyp[pire_pkg::FRAC_SHIFT +: OW]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_ox    <= r_o_cneg ? $signed(-w_oxm) : $signed(w_oxm);
        r_f_oy    <= r_o_sneg ? $signed(-w_oym) : $signed(w_oym);
        r_f_ex    <= r_o_ex;
        r_f_ey    <= r_o_ey;
        r_f_bound <= r_o_bound;
        r_f_below <= r_o_below;
    end

    // ---- differences to both foci ----
    logic                 r_d_vld;
    logic [MW-1:0]        r_d_mx1, r_d_my1, r_d_mx2, r_d_my2;
    logic [BW-1:0]        r_d_bound;
    logic                 r_d_below;
    logic signed [XW-1:0] w_dx1, w_dy1, w_dx2, w_dy2;

    assign w_dx1 = XW'(r_f_ex) - XW'(r_f_ox);
    assign w_dy1 = XW'(r_f_ey) - XW'(r_f_oy);
    assign w_dx2 = XW'(r_f_ex) + XW'(r_f_ox);
    assign w_dy2 = XW'(r_f_ey) + XW'(r_f_oy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_mx1   <= w_dx1[XW-1] ? MW'(-w_dx1) : MW'(w_dx1);
        r_d_my1   <= w_dy1[XW-1] ? MW'(-w_dy1) : MW'(w_dy1);
        r_d_mx2   <= w_dx2[XW-1] ? MW'(-w_dx2) : MW'(w_dx2);
        r_d_my2   <= w_dy2[XW-1] ? MW'(-w_dy2) : MW'(w_dy2);
        r_d_bound <= r_f_bound;
        r_d_below <= r_f_below;
    end

    // ---- squared distances ----
    logic              w_s1_vld, w_s2_vld;
    logic [2*RW-1:0]   w_s1_sum, w_s2_sum;
    logic [BW-1:0]     w_s1_bound;
    logic              w_s2_below;

    pire_sqsum #(
        .SIDE_W (BW)
    ) u_sqsum_1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_d_vld),
        .i_mx    (r_d_mx1),
        .i_my    (r_d_my1),
        .i_side  (r_d_bound),
        .o_vld   (w_s1_vld),
        .o_sum   (w_s1_sum),
        .o_side  (w_s1_bound)
    );

    pire_sqsum #(
        .SIDE_W (1)
    ) u_sqsum_2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_d_vld),
        .i_mx    (r_d_mx2),
        .i_my    (r_d_my2),
        .i_side  (r_d_below),
        .o_vld   (w_s2_vld),
        .o_sum   (w_s2_sum),
        .o_side  (w_s2_below)
    );

    // ---- distances ----
    logic          w_r1_vld, w_r2_vld;
    logic [RW-1:0] w_d1, w_d2;
    logic [BW-1:0] w_r1_bound;
    logic          w_r2_below;

    pire_isqrt #(
        .ROOT_W (RW),
        .SIDE_W (BW)
    ) u_isqrt_d1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_s1_vld),
        .i_rad   (w_s1_sum),
        .i_side  (w_s1_bound),
        .o_vld   (w_r1_vld),
        .o_root  (w_d1),
        .o_side  (w_r1_bound)
    );

    pire_isqrt #(
        .ROOT_W (RW),
        .SIDE_W (1)
    ) u_isqrt_d2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_s2_vld),
        .i_rad   (w_s2_sum),
        .i_side  (w_s2_below),
        .o_vld   (w_r2_vld),
        .o_root  (w_d2),
        .o_side  (w_r2_below)
    );

    // ---- compare against the major axis ----
    logic            r_out_vld, r_out_inside;
    logic [RW:0]     w_dsum;
    logic [RW+8:0]   w_lhs;

    assign w_dsum = (RW+1)'(w_d1) + (RW+1)'(w_d2);
    assign w_lhs  = {w_dsum, 8'h00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_r1_vld && w_r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        // a shape below one has no focal offset: report outside
        r_out_inside <= !w_r2_below && (w_lhs <= (RW+9)'(w_r1_bound));
    end

    assign o_done       = r_out_vld;
    assign o_inside_res = r_out_inside;

endmodule

`default_nettype wire

// ----- tb/inside_checker.sv -----
// Checker for the rotated-ellipse point test: predicts each verdict and compares.
// Depends on pire_pkg for the port widths and the unit shape; sits beside the block and only watches.
`timescale 1ns / 1ps

module inside_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    input  wire logic                                 busy,
    input  wire logic signed [pire_pkg::COORD_W-1:0]  i_point_x,
    input  wire logic signed [pire_pkg::COORD_W-1:0]  i_point_y,
    input  wire logic signed [pire_pkg::COORD_W-1:0]  i_center_x,
    input  wire logic signed [pire_pkg::COORD_W-1:0]  i_center_y,
    input  wire logic        [pire_pkg::COORD_W-1:0]  i_minor_radius,
    input  wire logic signed [pire_pkg::ANGLE_W-1:0]  i_rotation,
    input  wire logic        [pire_pkg::ASPECT_W-1:0] i_aspect,
    input  wire logic                                 o_done,
    input  wire logic                                 o_inside_res,
    output int                                        o_fail_count,
    output int                                        o_pending,
    output int                                        o_checked,
    output int                                        o_inside_seen
);

    // predicted verdicts in arrival order, far deeper than the pipeline
    logic        inside_expected [256];
    logic [31:0] n_issued;
    logic [31:0] n_retired;

    function automatic logic [63:0] isqrt_floor(logic [127:0] v);
        logic [127:0] res;
        logic [127:0] cand;
        res = '0;
        for (int b = 44; b >= 0; b--) begin
            cand = res | (128'd1 << b);
            if (cand * cand <= v)
                res = cand;
        end
        return res[63:0];
    endfunction

    function automatic logic [63:0] focus_distance(logic signed [63:0] dx,
                                                  logic signed [63:0] dy);
        logic [63:0] mx;
        logic [63:0] my;
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        return isqrt_floor({64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my});
    endfunction

    // sign(t) * floor(c*|t| / 2^24)
    function automatic logic signed [63:0] focal_component(logic [63:0] c,
                                                          logic signed [63:0] t);
        logic [63:0]  m;
        logic [127:0] p;
        m = t < 0 ? -t : t;
        p = {64'd0, c} * {64'd0, m};
        return t < 0 ? -$signed(p[87:24]) : $signed(p[87:24]);
    endfunction

    function automatic logic predict_inside(logic signed [31:0] px, logic signed [31:0] py,
                                            logic signed [31:0] cx, logic signed [31:0] cy,
                                            logic [31:0] r, logic [15:0] rot,
                                            logic [15:0] s);
        logic [63:0]        q, k, c, amag, a, a2, tc, ts, cp, cn, sp, sm, d1, d2, bound;
        logic signed [63:0] cs, sn, ox, oy, ex, ey;
        // no real focus below a shape of one
        if (s < pire_pkg::ASPECT_ONE)
            return 1'b0;
        q = {48'd0, s} * {48'd0, s} - 64'd65536;
        k = isqrt_floor({64'd0, q} << 16);
        c = ({32'd0, r} * k) >> 16;
        amag = rot[15] ? 64'h10000 - {48'd0, rot} : {48'd0, rot};
        a = amag << 11;
        a2 = (a * a) >> 24;
        tc = 64'd1 << 24;
        ts = a;
        cp = tc;
        cn = 0;
        sp = ts;
        sm = 0;
        for (int j = 1; j <= 13; j++) begin
            tc = ((tc * a2) >> 24) / 64'((2 * j - 1) * (2 * j));
            ts = ((ts * a2) >> 24) / 64'((2 * j) * (2 * j + 1));
            if (j % 2 == 1) begin
                cn += tc;
                sm += ts;
            end else begin
                cp += tc;
                sp += ts;
            end
        end
        cs = $signed(cp) - $signed(cn);
        sn = $signed(sp) - $signed(sm);
        if (rot[15])
            sn = -sn;
        ox = focal_component(c, cs);
        oy = focal_component(c, sn);
        ex = px;
        ex = ex - cx;
        ey = py;
        ey = ey - cy;
        d1 = focus_distance(ex - ox, ey - oy);
        d2 = focus_distance(ex + ox, ey + oy);
        bound = 64'd2 * {32'd0, r} * {48'd0, s};
        return ((d1 + d2) << 8) <= bound;
    endfunction

    initial begin
        o_fail_count  = 0;
        o_checked     = 0;
        o_inside_seen = 0;
        n_issued      = '0;
        n_retired     = '0;
    end

    assign o_pending = int'(n_issued - n_retired);

    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n) begin
            if (start && !busy) begin
                inside_expected[n_issued[7:0]] <= predict_inside(i_point_x, i_point_y,
                    i_center_x, i_center_y, i_minor_radius, i_rotation, i_aspect);
                n_issued <= n_issued + 32'd1;
            end
            if (o_done) begin
                if (n_issued == n_retired) begin
                    $error("result with no transaction outstanding: inside_res=%0b",
                           o_inside_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = inside_expected[n_retired[7:0]];
                    n_retired <= n_retired + 32'd1;
                    o_checked <= o_checked + 1;
                    if (o_inside_res)
                        o_inside_seen <= o_inside_seen + 1;
                    if (o_inside_res !== want) begin
                        $error("inside_res: expected %0b, actual %0b", want, o_inside_res);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the rotated-ellipse point test bench: clock, reset, stimulus, verdict.
// Depends on pire_pkg, point_in_rotated_ellipse and inside_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 130;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 start;
    logic                                 busy;
    logic signed [pire_pkg::COORD_W-1:0]  i_point_x;
    logic signed [pire_pkg::COORD_W-1:0]  i_point_y;
    logic signed [pire_pkg::COORD_W-1:0]  i_center_x;
    logic signed [pire_pkg::COORD_W-1:0]  i_center_y;
    logic        [pire_pkg::COORD_W-1:0]  i_minor_radius;
    logic signed [pire_pkg::ANGLE_W-1:0]  i_rotation;
    logic        [pire_pkg::ASPECT_W-1:0] i_aspect;
    logic                                 o_done;
    logic                                 o_inside_res;
    int                                   fail_count;
    int                                   pending;
    int                                   checked;
    int                                   inside_seen;
    int                                   idle_cycles;
    bit                                   no_gaps;

    point_in_rotated_ellipse dut (.*);

    inside_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_point_x, .i_point_y, .i_center_x,
        .i_center_y, .i_minor_radius, .i_rotation, .i_aspect, .o_done, .o_inside_res,
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked),
        .o_inside_seen(inside_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // drive one transaction and hold it until the block takes it
    task automatic send_test(logic [31:0] px, logic [31:0] py, logic [31:0] cx,
                             logic [31:0] cy, logic [31:0] r, logic [15:0] rot,
                             logic [15:0] s);
        int  gap;
        bit  taken;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_point_x      <= px;
        i_point_y      <= py;
        i_center_x     <= cx;
        i_center_y     <= cy;
        i_minor_radius <= r;
        i_rotation     <= rot;
        i_aspect       <= s;
        start          <= 1'b1;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic random_test();
        logic [31:0] cx, cy, r, px, py;
        logic [15:0] rot, s;
        int          span;
        if ($urandom_range(0, 3) == 0) begin
            // noise over the whole field ranges
            send_test($urandom, $urandom, $urandom, $urandom, $urandom,
                      16'($urandom), 16'($urandom));
        end else begin
            // points scattered around a plausible ellipse
            cx   = $urandom_range(0, 1) ? $urandom : $signed($urandom_range(0, 32'h3FFFFF))
                   - 32'sh200000;
            cy   = $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
            r    = $urandom_range(0, 3) == 0 ? $urandom_range(0, 32'hFFFFFF)
                                              : $urandom_range(32'h100, 32'hFFFFF);
            s    = 16'($urandom_range(0, 7) == 0 ? $urandom_range(16'h400, 16'hFFFF)
                                                  : $urandom_range(16'h100, 16'h400));
            rot  = 16'($urandom_range(0, 51472) - 25736);
            span = (r >> 7) * (s >> 8) * 3 + 1;
            if (span > 32'h3FFFFFFF || span <= 0)
                span = 32'h3FFFFFFF;
            px   = cx + ($signed($urandom_range(0, span)) - span / 2);
            py   = cy + ($signed($urandom_range(0, span)) - span / 2);
            send_test(px, py, cx, cy, r, rot, s);
        end
    endtask

    initial begin
        int waited;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_point_x      = '0;
        i_point_y      = '0;
        i_center_x     = '0;
        i_center_y     = '0;
        i_minor_radius = '0;
        i_rotation     = '0;
        i_aspect       = pire_pkg::ASPECT_ONE;
        idle_cycles    = 0;
        no_gaps        = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, circle, shape below one, zero radius, angle limits
        send_test(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, 16'h8000, 16'hFFFF);
        send_test(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'hFFFF_FFFF, 16'h7FFF, 16'hFFFF);
        send_test(0, 0, 0, 0, 0, 0, 16'h0100);
        send_test(32'h0001_0000, 0, 0, 0, 0, 0, 16'h0100);
        send_test(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 16'h0100);
        send_test(32'h0001_0001, 0, 0, 0, 32'h0001_0000, 0, 16'h0100);
        send_test(0, 0, 0, 0, 32'h0001_0000, 0, 16'h00FF);
        send_test(0, 0, 0, 0, 32'h0001_0000, 0, 16'h0000);
        send_test(32'h0002_0000, 0, 0, 0, 32'h0001_0000, 0, 16'h0200);
        send_test(32'h0002_0001, 0, 0, 0, 32'h0001_0000, 0, 16'h0200);
        send_test(0, 32'h0002_0000, 0, 0, 32'h0001_0000, 16'd12868, 16'h0200);
        send_test(0, 32'h0002_0000, 0, 0, 32'h0001_0000, -16'sd12868, 16'h0200);
        send_test(32'hFFFE_0000, 0, 0, 0, 32'h0001_0000, 16'd25736, 16'h0200);
        send_test(32'hFFFE_0000, 0, 0, 0, 32'h0001_0000, -16'sd25736, 16'h0200);
        send_test(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 0,
                  16'd6434, 16'hFFFF);
        send_test(32'h0010_0000, 32'h0003_0000, 0, 0, 32'h0004_0000, 16'd3000,
                  16'h0380);
        send_test(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF, 16'hFFFF,
                  16'h0101);
        send_test(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);

        // random: stretches with and without idling
        for (int n = 0; n < 500; n++) begin
            if (n % 60 == 0)
                no_gaps = $urandom_range(0, 2) == 0;
            random_test();
        end
        start <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 10 * DRAIN_WAIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d verdicts (%0d inside) over extremes, circles, sub-unit",
                 checked, inside_seen);
        $display("shapes, zero radius, full angle range and random ellipse scatter");
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (pending != 0)
                $error("%0d transactions never produced a result", pending);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
